// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

    // Item actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    // Transaction stage, also the no-ack status code of that stage
    localparam logic [2:0] STG_NONE   = 3'd0;
    localparam logic [2:0] STG_ADDR_W = 3'd1;
    localparam logic [2:0] STG_REG    = 3'd2;
    localparam logic [2:0] STG_ADDR_R = 3'd3;
    localparam logic [2:0] STG_DATA   = 3'd4;

    localparam logic [2:0] STATUS_OK = 3'd0;

    localparam logic [7:0] MSB_MASK     = 8'h80;
    localparam logic [7:0] HP_RESET     = 8'd5;
    localparam logic [7:0] POLL_RESET   = 8'd10;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Config register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_START_B   = 5'd2,
        PH_TX_LOW    = 5'd3,
        PH_TX_HIGH   = 5'd4,
        PH_ACK_LOW   = 5'd5,
        PH_ACK_HIGH  = 5'd6,
        PH_RS_A      = 5'd7,
        PH_RS_B      = 5'd8,
        PH_RS_C      = 5'd9,
        PH_RX_LOW    = 5'd10,
        PH_RX_HIGH   = 5'd11,
        PH_MACK_LOW  = 5'd12,
        PH_MACK_HIGH = 5'd13,
        PH_STOP_A    = 5'd14,
        PH_STOP_B    = 5'd15,
        PH_STOP_C    = 5'd16
    } t_phase;

    typedef struct packed {
        logic [1:0] action;
        logic       sda_in;
        logic [6:0] device_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic       is_read;
        logic [7:0] write_byte;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [3:0] fault_byte;
    } t_result;

endpackage

// ----- rtl/i2cm_ram.sv -----
// Generic single-port-write, registered-read RAM.
module i2cm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/i2cm_seq.sv -----
// Bus sequencer: transaction state, write buffer and per-item result logic.
module i2cm_seq import i2cm_pkg::*; #(
    parameter int BUF_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item      i_item,
    input  logic [7:0] i_half_period,
    input  logic [7:0] i_poll_limit,
    output t_result    o_result
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int SW = (CW > 5) ? CW : 5;

    t_phase        r_phase, n_phase;
    logic [7:0]    r_tick, n_tick;
    logic [7:0]    r_poll, n_poll;
    logic [3:0]    r_bit, n_bit;
    logic [CW-1:0] r_byte, n_byte;
    logic [7:0]    r_shift, n_shift;
    logic [6:0]    r_addr, n_addr;
    logic [7:0]    r_reg, n_reg;
    logic [CW-1:0] r_count, n_count;
    logic          r_read, n_read;
    logic [CW-1:0] r_load, n_load;
    logic [2:0]    r_stage, n_stage;
    logic [2:0]    r_status, n_status;
    logic [3:0]    r_fault, n_fault;
    logic          r_scl, n_scl;
    logic          r_sda_low, n_sda_low;

    logic          half_step;
    logic [7:0]    hp, lim, tick_inc, poll_inc, rx_shift, tx_shift, tx_byte;
    logic [3:0]    bit_inc;
    logic [CW:0]   byte_inc;
    logic          last_byte;
    logic [SW-1:0] cnt_clip;
    logic          buf_we;
    logic [AW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;

    i2cm_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_load[AW-1:0]),
        .i_wdata (i_item.write_byte),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // Prefetch the next data byte; the index settles long before it is sent
    assign buf_raddr = (r_stage == STG_DATA) ? AW'(r_byte + CW'(1)) : '0;

    assign hp        = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign lim       = (i_poll_limit == 8'd0) ? 8'd1 : i_poll_limit;
    assign tick_inc  = r_tick + 8'd1;
    assign poll_inc  = r_poll + 8'd1;
    assign bit_inc   = r_bit + 4'd1;
    assign byte_inc  = {1'b0, r_byte} + {{CW{1'b0}}, 1'b1};
    assign last_byte = byte_inc >= {1'b0, r_count};
    assign rx_shift  = {r_shift[6:0], i_item.sda_in};
    assign tx_shift  = {r_shift[6:0], 1'b0};
    assign half_step = (i_item.action == ACT_TICK) && (r_phase != PH_IDLE)
                       && (tick_inc >= hp);
    assign buf_we    = i_step && (i_item.action == ACT_LOAD) && (r_phase == PH_IDLE)
                       && (r_load < CW'(BUF_DEPTH));

    always_comb begin
        cnt_clip = SW'(i_item.byte_count);
        if (cnt_clip == '0) begin
            cnt_clip = SW'(1);
        end
        if (cnt_clip > SW'(BUF_DEPTH)) begin
            cnt_clip = SW'(BUF_DEPTH);
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_poll    = r_poll;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_shift   = r_shift;
        n_addr    = r_addr;
        n_reg     = r_reg;
        n_count   = r_count;
        n_read    = r_read;
        n_load    = r_load;
        n_stage   = r_stage;
        n_status  = r_status;
        n_fault   = r_fault;
        n_scl     = r_scl;
        n_sda_low = r_sda_low;
        tx_byte   = 8'd0;

        case (i_item.action)
            ACT_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_tick = half_step ? 8'd0 : tick_inc;
                end
            end
            ACT_START: begin
                if (r_phase == PH_IDLE) begin
                    n_addr    = i_item.device_addr;
                    n_reg     = i_item.reg_addr;
                    n_count   = CW'(cnt_clip);
                    n_read    = i_item.is_read;
                    n_load    = '0;
                    n_tick    = '0;
                    n_poll    = '0;
                    n_bit     = '0;
                    n_byte    = '0;
                    n_shift   = '0;
                    n_stage   = STG_NONE;
                    n_status  = STATUS_OK;
                    n_fault   = '0;
                    n_phase   = PH_START_A;
                    n_scl     = 1'b1;
                    n_sda_low = 1'b0;
                end
            end
            ACT_LOAD: begin
                if (buf_we) begin
                    n_load = r_load + CW'(1);
                end
            end
            default: ;
        endcase

        if (half_step) begin
            unique case (r_phase)
                PH_START_A: begin
                    n_phase   = PH_START_B;
                    n_scl     = 1'b1;
                    n_sda_low = 1'b1;
                end
                PH_START_B: begin
                    n_stage = STG_ADDR_W;
                    n_phase = PH_TX_LOW;
                    tx_byte = {r_addr, 1'b0};
                end
                PH_TX_LOW: begin
                    n_phase = PH_TX_HIGH;
                    n_scl   = 1'b1;
                end
                PH_TX_HIGH: begin
                    n_shift = tx_shift;
                    n_bit   = bit_inc;
                    n_scl   = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_phase   = PH_ACK_LOW;
                        n_sda_low = 1'b0;
                    end else begin
                        n_phase   = PH_TX_LOW;
                        n_sda_low = (tx_shift & MSB_MASK) == 8'd0;
                    end
                end
                PH_ACK_LOW: begin
                    n_phase = PH_ACK_HIGH;
                    n_scl   = 1'b1;
                    n_poll  = '0;
                end
                PH_ACK_HIGH: begin
                    if (!i_item.sda_in) begin
                        case (r_stage)
                            STG_ADDR_W: begin
                                n_stage = STG_REG;
                                n_phase = PH_TX_LOW;
                                tx_byte = r_reg;
                            end
                            STG_REG: begin
                                if (r_read) begin
                                    n_phase   = PH_RS_A;
                                    n_scl     = 1'b0;
                                    n_sda_low = 1'b0;
                                end else begin
                                    n_stage = STG_DATA;
                                    n_byte  = '0;
                                    n_phase = PH_TX_LOW;
                                    tx_byte = buf_rdata;
                                end
                            end
                            STG_ADDR_R: begin
                                n_byte    = '0;
                                n_bit     = '0;
                                n_shift   = '0;
                                n_phase   = PH_RX_LOW;
                                n_scl     = 1'b0;
                                n_sda_low = 1'b0;
                            end
                            default: begin
                                n_byte = byte_inc[CW-1:0];
                                if (last_byte) begin
                                    n_status  = STATUS_OK;
                                    n_fault   = '0;
                                    n_phase   = PH_STOP_A;
                                    n_scl     = 1'b0;
                                    n_sda_low = 1'b1;
                                end else begin
                                    n_phase = PH_TX_LOW;
                                    tx_byte = buf_rdata;
                                end
                            end
                        endcase
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= lim) begin
                            n_status  = r_stage;
                            n_fault   = (r_stage == STG_DATA) ? 4'(r_byte) : 4'd0;
                            n_phase   = PH_STOP_A;
                            n_scl     = 1'b0;
                            n_sda_low = 1'b1;
                        end
                    end
                end
                PH_RS_A: begin
                    n_phase = PH_RS_B;
                    n_scl   = 1'b1;
                end
                PH_RS_B: begin
                    n_phase   = PH_RS_C;
                    n_sda_low = 1'b1;
                end
                PH_RS_C: begin
                    n_stage = STG_ADDR_R;
                    n_phase = PH_TX_LOW;
                    tx_byte = {r_addr, 1'b1};
                end
                PH_RX_LOW: begin
                    n_phase = PH_RX_HIGH;
                    n_scl   = 1'b1;
                end
                PH_RX_HIGH: begin
                    n_shift = rx_shift;
                    n_bit   = bit_inc;
                    n_scl   = 1'b0;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        n_phase   = PH_MACK_LOW;
                        n_sda_low = !last_byte;
                    end else begin
                        n_phase = PH_RX_LOW;
                    end
                end
                PH_MACK_LOW: begin
                    n_phase = PH_MACK_HIGH;
                    n_scl   = 1'b1;
                end
                PH_MACK_HIGH: begin
                    if (last_byte) begin
                        n_status  = STATUS_OK;
                        n_fault   = '0;
                        n_phase   = PH_STOP_A;
                        n_scl     = 1'b0;
                        n_sda_low = 1'b1;
                    end else begin
                        n_byte    = byte_inc[CW-1:0];
                        n_bit     = '0;
                        n_shift   = '0;
                        n_phase   = PH_RX_LOW;
                        n_scl     = 1'b0;
                        n_sda_low = 1'b0;
                    end
                end
                PH_STOP_A: begin
                    n_phase = PH_STOP_B;
                    n_scl   = 1'b1;
                end
                PH_STOP_B: begin
                    n_phase   = PH_STOP_C;
                    n_sda_low = 1'b0;
                end
                PH_STOP_C: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
                default: begin
                    n_phase   = PH_IDLE;
                    n_scl     = 1'b1;
                    n_sda_low = 1'b0;
                end
            endcase

            // Load the byte shifter when a new byte goes out
            if ((n_phase == PH_TX_LOW) && (r_phase != PH_TX_HIGH)) begin
                n_shift   = tx_byte;
                n_bit     = '0;
                n_scl     = 1'b0;
                n_sda_low = (tx_byte & MSB_MASK) == 8'd0;
            end
        end
    end

    // Result outputs
    always_comb begin
        o_result              = '0;
        o_result.scl_level    = n_scl;
        o_result.sda_pull_low = n_sda_low;
        o_result.busy_res     = n_phase != PH_IDLE;
        if (half_step && (r_phase == PH_RX_HIGH) && (bit_inc >= BITS_PER_BYTE)) begin
            o_result.read_data  = rx_shift;
            o_result.read_valid = 1'b1;
            o_result.read_last  = last_byte;
        end
        if (half_step && (r_phase == PH_STOP_C)) begin
            o_result.done_res   = 1'b1;
            o_result.status     = r_status;
            o_result.fault_byte = r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_poll    <= '0;
            r_bit     <= '0;
            r_byte    <= '0;
            r_shift   <= '0;
            r_addr    <= '0;
            r_reg     <= '0;
            r_count   <= '0;
            r_read    <= 1'b0;
            r_load    <= '0;
            r_stage   <= STG_NONE;
            r_status  <= STATUS_OK;
            r_fault   <= '0;
            r_scl     <= 1'b1;
            r_sda_low <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_poll    <= n_poll;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_count   <= n_count;
            r_read    <= n_read;
            r_load    <= n_load;
            r_stage   <= n_stage;
            r_status  <= n_status;
            r_fault   <= n_fault;
            r_scl     <= n_scl;
            r_sda_low <= n_sda_low;
        end
    end

endmodule

// ----- rtl/i2c_register_access_master_top.sv -----
// Top level of the tick-paced I2C register access master.
// A result passes the item register, then sequencer logic into the result register.
// Throughput: one item per clock unless the result side stalls; the input stall follows it combinationally.
// Reset (i_rst_n low, synchronous): sequencer idle, SCL high, SDA released,
// config back to defaults; the write buffer RAM keeps its contents.
module i2c_register_access_master_top import i2cm_pkg::*; #(
    parameter int BUF_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic       i_sda_in,
    input  logic [6:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [4:0] i_byte_count,
    input  logic       i_is_read,
    input  logic [7:0] i_write_byte,
    // Result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_pull_low,
    output logic [7:0] o_read_data,
    output logic       o_read_valid,
    output logic       o_read_last,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [2:0] o_status,
    output logic [3:0] o_fault_byte,
    // Config write port
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_half_period;
    logic [7:0] r_poll_limit;

    logic       in_accept;
    logic       advance;
    t_result    seq_result;

    // Advance the held item whenever the result register is free or drains now
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.action      <= i_action;
            r_in.sda_in      <= i_sda_in;
            r_in.device_addr <= i_device_addr;
            r_in.reg_addr    <= i_reg_addr;
            r_in.byte_count  <= i_byte_count;
            r_in.is_read     <= i_is_read;
            r_in.write_byte  <= i_write_byte;
        end
    end

    // Config registers; the user must write them only while no transfer is in flight, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HP_RESET;
            r_poll_limit  <= POLL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_wdata;
                CFG_POLL_LIMIT:  r_poll_limit  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer commits its state on each advance
    i2cm_seq #(.BUF_DEPTH(BUF_DEPTH)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_item        (r_in),
        .i_half_period (r_half_period),
        .i_poll_limit  (r_poll_limit),
        .o_result      (seq_result)
    );

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_out.scl_level;
    assign o_sda_pull_low = r_out.sda_pull_low;
    assign o_read_data    = r_out.read_data;
    assign o_read_valid   = r_out.read_valid;
    assign o_read_last    = r_out.read_last;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_status       = r_out.status;
    assign o_fault_byte   = r_out.fault_byte;

endmodule

// ----- tb/sv/i2cm_seq_check.sv -----
`timescale 1ns / 100ps
// Bus sequencer predictor and result comparison for the I2C register access master.
module i2cm_seq_check import i2cm_pkg::*; #(
    parameter int BUF_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_action,
    input  logic       i_sda_in,
    input  logic [6:0] i_device_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [4:0] i_byte_count,
    input  logic       i_is_read,
    input  logic [7:0] i_write_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_scl_level,
    input  logic       i_sda_pull_low,
    input  logic [7:0] i_read_data,
    input  logic       i_read_valid,
    input  logic       i_read_last,
    input  logic       i_busy_res,
    input  logic       i_done_res,
    input  logic [2:0] i_status,
    input  logic [3:0] i_fault_byte,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_transfers_in,
    output int         o_txn_closed,
    output int         o_txn_nacked,
    output int         o_bytes_read
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // Mirror of the sequencer and its settings
    logic [7:0] hp_cfg;
    logic [7:0] lim_cfg;
    t_phase     ph;
    logic [7:0] tick_cnt;
    logic [7:0] poll_cnt;
    logic [3:0] bit_idx;
    logic [4:0] byte_idx;
    logic [7:0] shreg;
    logic [6:0] addr_q;
    logic [7:0] reg_q;
    logic [4:0] count_q;
    logic       read_q;
    logic [4:0] load_cnt;
    logic [7:0] wbuf [BUF_DEPTH];
    logic [2:0] stg;
    logic [2:0] st_code;
    logic [3:0] fault_idx;
    logic       scl;
    logic       sda_low;

    t_result bus_outcomes [$];

    int fail_n    = 0;
    int waiting   = 0;
    int taken     = 0;
    int closed    = 0;
    int nacked    = 0;
    int rx_bytes  = 0;

    assign o_fail_count   = fail_n;
    assign o_pending      = waiting;
    assign o_transfers_in = taken;
    assign o_txn_closed   = closed;
    assign o_txn_nacked   = nacked;
    assign o_bytes_read   = rx_bytes;

    function automatic void shift_out(input logic [7:0] b);
        shreg   = b;
        bit_idx = '0;
        ph      = PH_TX_LOW;
        scl     = 1'b0;
        sda_low = ((b & MSB_MASK) == 8'd0);
    endfunction

    function automatic void begin_stop(input logic [2:0] st, input logic [3:0] fb);
        st_code   = st;
        fault_idx = fb;
        ph        = PH_STOP_A;
        scl       = 1'b0;
        sda_low   = 1'b1;
    endfunction

    function automatic void after_ack();
        case (stg)
            STG_ADDR_W: begin
                stg = STG_REG;
                shift_out(reg_q);
            end
            STG_REG: begin
                if (read_q) begin
                    ph      = PH_RS_A;
                    scl     = 1'b0;
                    sda_low = 1'b0;
                end else begin
                    stg      = STG_DATA;
                    byte_idx = '0;
                    shift_out(wbuf[0]);
                end
            end
            STG_ADDR_R: begin
                byte_idx = '0;
                bit_idx  = '0;
                shreg    = '0;
                ph       = PH_RX_LOW;
                scl      = 1'b0;
                sda_low  = 1'b0;
            end
            default: begin
                byte_idx = byte_idx + 5'd1;
                if (byte_idx >= count_q)
                    begin_stop(STATUS_OK, 4'd0);
                else
                    shift_out(wbuf[AW'(byte_idx)]);
            end
        endcase
    endfunction

    // One SCL half period of the sequencer
    function automatic void half_step(input logic sda, inout t_result r);
        logic [7:0] lim;
        logic       last;
        lim = (lim_cfg == 8'd0) ? 8'd1 : lim_cfg;
        case (ph)
            PH_START_A: begin
                ph      = PH_START_B;
                scl     = 1'b1;
                sda_low = 1'b1;
            end
            PH_START_B: begin
                stg = STG_ADDR_W;
                shift_out({addr_q, 1'b0});
            end
            PH_TX_LOW: begin
                ph  = PH_TX_HIGH;
                scl = 1'b1;
            end
            PH_TX_HIGH: begin
                shreg   = shreg << 1;
                bit_idx = bit_idx + 4'd1;
                scl     = 1'b0;
                if (bit_idx >= BITS_PER_BYTE) begin
                    ph      = PH_ACK_LOW;
                    sda_low = 1'b0;
                end else begin
                    ph      = PH_TX_LOW;
                    sda_low = ((shreg & MSB_MASK) == 8'd0);
                end
            end
            PH_ACK_LOW: begin
                ph       = PH_ACK_HIGH;
                scl      = 1'b1;
                poll_cnt = '0;
            end
            PH_ACK_HIGH: begin
                if (!sda) begin
                    after_ack();
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                    if (poll_cnt >= lim)
                        begin_stop(stg, (stg == STG_DATA) ? byte_idx[3:0] : 4'd0);
                end
            end
            PH_RS_A: begin
                ph  = PH_RS_B;
                scl = 1'b1;
            end
            PH_RS_B: begin
                ph      = PH_RS_C;
                sda_low = 1'b1;
            end
            PH_RS_C: begin
                stg = STG_ADDR_R;
                shift_out({addr_q, 1'b1});
            end
            PH_RX_LOW: begin
                ph  = PH_RX_HIGH;
                scl = 1'b1;
            end
            PH_RX_HIGH: begin
                shreg   = {shreg[6:0], sda};
                bit_idx = bit_idx + 4'd1;
                scl     = 1'b0;
                if (bit_idx >= BITS_PER_BYTE) begin
                    last         = ((byte_idx + 5'd1) >= count_q);
                    r.read_data  = shreg;
                    r.read_valid = 1'b1;
                    r.read_last  = last;
                    ph           = PH_MACK_LOW;
                    sda_low      = ~last;
                end else begin
                    ph = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: begin
                ph  = PH_MACK_HIGH;
                scl = 1'b1;
            end
            PH_MACK_HIGH: begin
                if ((byte_idx + 5'd1) >= count_q) begin
                    begin_stop(STATUS_OK, 4'd0);
                end else begin
                    byte_idx = byte_idx + 5'd1;
                    bit_idx  = '0;
                    shreg    = '0;
                    ph       = PH_RX_LOW;
                    scl      = 1'b0;
                    sda_low  = 1'b0;
                end
            end
            PH_STOP_A: begin
                ph  = PH_STOP_B;
                scl = 1'b1;
            end
            PH_STOP_B: begin
                ph      = PH_STOP_C;
                sda_low = 1'b0;
            end
            PH_STOP_C: begin
                ph           = PH_IDLE;
                tick_cnt     = '0;
                r.done_res   = 1'b1;
                r.status     = st_code;
                r.fault_byte = fault_idx;
            end
            default: begin
                ph      = PH_IDLE;
                scl     = 1'b1;
                sda_low = 1'b0;
            end
        endcase
    endfunction

    // Bus levels and events that one accepted item produces
    function automatic t_result bus_response(input t_item it);
        t_result    r;
        logic [7:0] hp;
        logic [4:0] c;
        r  = '0;
        hp = (hp_cfg == 8'd0) ? 8'd1 : hp_cfg;
        case (it.action)
            ACT_TICK: begin
                if (ph != PH_IDLE) begin
                    tick_cnt = tick_cnt + 8'd1;
                    if (tick_cnt >= hp) begin
                        tick_cnt = '0;
                        half_step(it.sda_in, r);
                    end
                end
            end
            ACT_START: begin
                if (ph == PH_IDLE) begin
                    addr_q = it.device_addr;
                    reg_q  = it.reg_addr;
                    c      = it.byte_count;
                    if (c == 5'd0)
                        c = 5'd1;
                    if (c > BUF_DEPTH)
                        c = 5'(BUF_DEPTH);
                    count_q   = c;
                    read_q    = it.is_read;
                    load_cnt  = '0;
                    tick_cnt  = '0;
                    poll_cnt  = '0;
                    bit_idx   = '0;
                    byte_idx  = '0;
                    shreg     = '0;
                    stg       = STG_NONE;
                    st_code   = STATUS_OK;
                    fault_idx = '0;
                    ph        = PH_START_A;
                    scl       = 1'b1;
                    sda_low   = 1'b0;
                end
            end
            ACT_LOAD: begin
                if (ph == PH_IDLE && load_cnt < BUF_DEPTH) begin
                    wbuf[AW'(load_cnt)] = it.write_byte;
                    load_cnt            = load_cnt + 5'd1;
                end
            end
            default: ;
        endcase
        r.scl_level    = scl;
        r.sda_pull_low = sda_low;
        r.busy_res     = (ph != PH_IDLE);
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("scl=%b sda_low=%b data=%h rv=%b rl=%b busy=%b done=%b st=%0d fb=%0d",
                         r.scl_level, r.sda_pull_low, r.read_data, r.read_valid, r.read_last,
                         r.busy_res, r.done_res, r.status, r.fault_byte);
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            hp_cfg    = HP_RESET;
            lim_cfg   = POLL_RESET;
            ph        = PH_IDLE;
            tick_cnt  = '0;
            poll_cnt  = '0;
            bit_idx   = '0;
            byte_idx  = '0;
            shreg     = '0;
            addr_q    = '0;
            reg_q     = '0;
            count_q   = '0;
            read_q    = 1'b0;
            load_cnt  = '0;
            stg       = STG_NONE;
            st_code   = STATUS_OK;
            fault_idx = '0;
            scl       = 1'b1;
            sda_low   = 1'b0;
            bus_outcomes.delete();
            waiting   = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_HALF_PERIOD: hp_cfg  = i_cfg_wdata;
                    CFG_POLL_LIMIT:  lim_cfg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                it.action      = i_action;
                it.sda_in      = i_sda_in;
                it.device_addr = i_device_addr;
                it.reg_addr    = i_reg_addr;
                it.byte_count  = i_byte_count;
                it.is_read     = i_is_read;
                it.write_byte  = i_write_byte;
                want = bus_response(it);
                if (want.done_res) begin
                    closed++;
                    if (want.status != STATUS_OK)
                        nacked++;
                end
                if (want.read_valid)
                    rx_bytes++;
                bus_outcomes.push_back(want);
                waiting++;
                taken++;
            end
            if (i_out_valid && !i_out_stall) begin
                got.scl_level    = i_scl_level;
                got.sda_pull_low = i_sda_pull_low;
                got.read_data    = i_read_data;
                got.read_valid   = i_read_valid;
                got.read_last    = i_read_last;
                got.busy_res     = i_busy_res;
                got.done_res     = i_done_res;
                got.status       = i_status;
                got.fault_byte   = i_fault_byte;
                if (bus_outcomes.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: result transfer with nothing outstanding: %s",
                                 $time, show(got));
                end else begin
                    want = bus_outcomes.pop_front();
                    waiting--;
                    if (got.scl_level !== want.scl_level
                            || got.sda_pull_low !== want.sda_pull_low
                            || got.read_data !== want.read_data
                            || got.read_valid !== want.read_valid
                            || got.read_last !== want.read_last
                            || got.busy_res !== want.busy_res
                            || got.done_res !== want.done_res
                            || got.status !== want.status
                            || got.fault_byte !== want.fault_byte) begin
                        fail_n++;
                        if (fail_n <= 10) begin
                            $display("%0t: mismatch, expected %s", $time, show(want));
                            $display("%0t:           actual   %s", $time, show(got));
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_i2c_register_access_master_top.sv -----
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the I2C register access master.
module tb_i2c_register_access_master_top import i2cm_pkg::*; ();

    localparam int BUF_DEPTH      = 16;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
    localparam int SETTLE_CYCLES  = 4;     // item and result register, with margin
    localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
    localparam logic [1:0] ACT_NONE = 2'd3;  // unused action, ignored by the block

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_action      = ACT_TICK;
    logic       i_sda_in      = 1'b0;
    logic [6:0] i_device_addr = '0;
    logic [7:0] i_reg_addr    = '0;
    logic [4:0] i_byte_count  = '0;
    logic       i_is_read     = 1'b0;
    logic [7:0] i_write_byte  = '0;
    logic       i_out_stall   = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_index   = CFG_HALF_PERIOD;
    logic [7:0] i_cfg_wdata   = '0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_scl_level;
    logic       o_sda_pull_low;
    logic [7:0] o_read_data;
    logic       o_read_valid;
    logic       o_read_last;
    logic       o_busy_res;
    logic       o_done_res;
    logic [2:0] o_status;
    logic [3:0] o_fault_byte;

    int fail_count;
    int pending;
    int transfers_in;
    int txn_closed;
    int txn_nacked;
    int bytes_read;

    int         send_idle_pct = 0;   // owned by the stimulus process
    int         stall_pct     = 0;   // written with NBAs, read by the stall process
    int         hold_token    = 0;
    int         hold_seen     = 0;
    int         hold_left     = 0;
    int         quiet_cycles  = 0;
    logic [7:0] cur_hp        = HP_RESET;

    i2c_register_access_master_top #(.BUF_DEPTH(BUF_DEPTH)) DUT (.*);

    i2cm_seq_check #(.BUF_DEPTH(BUF_DEPTH)) CHK (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_sda_in       (i_sda_in),
        .i_device_addr  (i_device_addr),
        .i_reg_addr     (i_reg_addr),
        .i_byte_count   (i_byte_count),
        .i_is_read      (i_is_read),
        .i_write_byte   (i_write_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_scl_level    (o_scl_level),
        .i_sda_pull_low (o_sda_pull_low),
        .i_read_data    (o_read_data),
        .i_read_valid   (o_read_valid),
        .i_read_last    (o_read_last),
        .i_busy_res     (o_busy_res),
        .i_done_res     (o_done_res),
        .i_status       (o_status),
        .i_fault_byte   (o_fault_byte),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_transfers_in (transfers_in),
        .o_txn_closed   (txn_closed),
        .o_txn_nacked   (txn_nacked),
        .o_bytes_read   (bytes_read)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: random stall, or a long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run if no transfer happens on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Fully random item; callers override the fields that matter
    function automatic t_item noise_item();
        t_item it;
        it.action      = 2'($urandom_range(3));
        it.sda_in      = 1'($urandom_range(1));
        it.device_addr = 7'($urandom_range(127));
        it.reg_addr    = 8'($urandom_range(255));
        it.byte_count  = 5'($urandom_range(31));
        it.is_read     = 1'($urandom_range(1));
        it.write_byte  = 8'($urandom_range(255));
        return it;
    endfunction

    // Offer one item and hold it until the transfer; called right after a rising edge
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= it.action;
        i_sda_in      <= it.sda_in;
        i_device_addr <= it.device_addr;
        i_reg_addr    <= it.reg_addr;
        i_byte_count  <= it.byte_count;
        i_is_read     <= it.is_read;
        i_write_byte  <= it.write_byte;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers once every item in flight has drained
    task automatic configure(input logic [7:0] hp, input logic [7:0] lim);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_HALF_PERIOD;
        i_cfg_wdata <= hp;
        @(posedge i_clk);
        i_cfg_index <= CFG_POLL_LIMIT;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_hp = (hp == 8'd0) ? 8'd1 : hp;
    endtask

    // Run transactions: loads, a start, then ticks with an SDA bias picked per transaction.
    // Tick count follows a rough estimate of the transaction length at the current pace.
    task automatic run_phase(input int n_items, input int idle_p, input int stall_p);
        t_item it;
        int    sent;
        int    p_one;
        int    loads;
        int    cnt;
        int    ticks;
        int    roll;
        int    t;
        send_idle_pct = idle_p;
        stall_pct    <= stall_p;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(2))
                0:       p_one = 5;
                1:       p_one = 25;
                default: p_one = 50;
            endcase
            // loads only land while the bus is idle
            loads = $urandom_range(3);
            repeat (loads) begin
                it = noise_item();
                it.action = ACT_LOAD;
                send_item(it);
            end
            // mostly short transactions, a few long ones and out-of-range counts
            roll = $urandom_range(99);
            it = noise_item();
            it.action = ACT_START;
            if (roll < 55)
                it.byte_count = 5'd1;
            else if (roll < 85)
                it.byte_count = 5'($urandom_range(4, 2));
            else if (roll < 95)
                it.byte_count = 5'($urandom_range(BUF_DEPTH, 5));
            else if (roll[0])
                it.byte_count = 5'd0;
            else
                it.byte_count = 5'($urandom_range(31, BUF_DEPTH + 1));
            send_item(it);
            cnt = (it.byte_count == 5'd0) ? 1
                : (it.byte_count > BUF_DEPTH) ? BUF_DEPTH : int'(it.byte_count);
            ticks = (8 + 19 * (cnt + 3)) * int'(cur_hp);
            if (ticks > n_items - sent)
                ticks = (n_items - sent < 20) ? 20 : n_items - sent;
            for (t = 0; t < ticks; t++) begin
                it = noise_item();
                // keep a little noise in the tick stream
                if ($urandom_range(99) >= 3) begin
                    it.action = ACT_TICK;
                    it.sda_in = ($urandom_range(99) < p_one);
                end
                send_item(it);
            end
            sent += loads + 1 + ticks;
        end
    endtask

    initial begin : stimulus
        t_item it;
        int    i;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tick while idle and the unused action, all other bits high
        it = '1;
        it.action = ACT_TICK;
        send_item(it);
        it.action = ACT_NONE;
        send_item(it);
        // Fill the whole buffer, then one load more that must be dropped
        for (i = 0; i < BUF_DEPTH + 1; i++) begin
            it = '0;
            it.action = ACT_LOAD;
            it.write_byte = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255));
            send_item(it);
        end
        // Write with zero count and top address, then start and load while busy
        it = '0;
        it.action      = ACT_START;
        it.device_addr = '1;
        it.reg_addr    = '1;
        it.byte_count  = 5'd0;
        send_item(it);
        it = '0;
        it.action     = ACT_START;
        it.byte_count = '1;
        it.is_read    = 1'b1;
        send_item(it);
        it = '0;
        it.action     = ACT_LOAD;
        it.write_byte = 8'hA5;
        send_item(it);
        repeat (3) begin
            it = '0;
            it.action = ACT_TICK;
            send_item(it);
        end

        // Random phases across register settings and idle patterns
        configure(8'd1, 8'd10);
        run_phase(130, 0, 0);
        configure(8'd1, 8'd1);
        run_phase(130, 68, 0);
        configure(8'd2, 8'd3);
        run_phase(130, 0, 68);
        configure(8'd255, 8'd255);
        run_phase(300, 24, 24);
        // Zero registers; hold the result side while items keep coming
        configure(8'd0, 8'd0);
        hold_token <= hold_token + 1;
        run_phase(130, 0, 0);
        configure(8'd1, 8'd2);
        run_phase(130, 24, 24);
        configure(8'd3, 8'd1);
        run_phase(130, 68, 0);
        configure(8'd1, 8'd255);
        run_phase(130, 0, 68);

        stall_pct <= 0;
        drain();
        repeat (8) @(posedge i_clk);

        $display("Run: %0d item transfers, %0d transactions closed (%0d on a missing ack),",
                 transfers_in, txn_closed, txn_nacked);
        $display("     %0d bytes read; half period and poll limit 0 to 255, idle and stall to 68%%",
                 bytes_read);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
